@@ sv/bf5_pkg.sv @@
`default_nettype none

package bf5_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int WINDOW_DEF    = 5;

  // Fixed field widths.
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int COORD_W = 11;
  localparam int CSUM_W  = 11;

  localparam int PIX_MAX  = (1 << PIX_W) - 1;
  localparam int FW_RESET = 640;

  // Output queue.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [COORD_W-1:0] ROW_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0]   mean_value;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } bf5_result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bf5_mem_ctl_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } bf5_col_ctl_t;

endpackage

`default_nettype wire

@@ sv/bf5_if.sv @@
`default_nettype none

interface bf5_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bf5_pkg::PIX_W-1:0]  pixel;
  logic                       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bf5_res_if;
  logic                         valid;
  logic                         ready;
  logic [bf5_pkg::PIX_W-1:0]    mean_value;
  logic [bf5_pkg::COORD_W-1:0]  center_row;
  logic [bf5_pkg::COORD_W-1:0]  center_col;

  modport source (output valid, output mean_value, output center_row, output center_col,
                  input ready);
  modport sink   (input valid, input mean_value, input center_row, input center_col,
                  output ready);
endinterface

`default_nettype wire

@@ sv/bf5_line_cell.sv @@
`default_nettype none

// One line store of the vertical cascade. It reads the sample stored at the
// current column, takes the sample from the cell above in its place, and adds
// what it read to the running column sum.
module bf5_line_cell #(
  parameter int DEPTH = bf5_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire bf5_pkg::bf5_mem_ctl_t        ctl,
  input  wire logic [AW-1:0]                rd_addr,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [bf5_pkg::PIX_W-1:0]    wr_data,
  input  wire logic [bf5_pkg::CSUM_W-1:0]   sum_in,
  output logic [bf5_pkg::CSUM_W-1:0]        sum_out,
  output logic [bf5_pkg::PIX_W-1:0]         tap_out
);

  logic [bf5_pkg::PIX_W-1:0] mem_r [DEPTH];
  logic [bf5_pkg::PIX_W-1:0] rd_data_r;
  logic [bf5_pkg::PIX_W-1:0] byp_data_r;
  logic                      byp_sel_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // A read that hits the column being written in the same cycle must see
  // the new sample, so it is forwarded around the memory.
  always_ff @(posedge clk) begin
    byp_sel_r  <= ctl.rd_en && ctl.wr_en && (rd_addr == wr_addr);
    byp_data_r <= wr_data;
  end

  assign tap_out = byp_sel_r ? byp_data_r : rd_data_r;
  assign sum_out = sum_in + bf5_pkg::CSUM_W'(tap_out);

endmodule

`default_nettype wire

@@ sv/bf5_window_sum.sv @@
`default_nettype none

// Holds the last WINDOW column sums and registers their total.
module bf5_window_sum #(
  parameter int WINDOW = bf5_pkg::WINDOW_DEF,
  localparam int TOT_W = $clog2(WINDOW * WINDOW * bf5_pkg::PIX_MAX + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bf5_pkg::bf5_col_ctl_t       ctl,
  input  wire logic [bf5_pkg::CSUM_W-1:0]  col_sum,
  output logic [TOT_W-1:0]                 total_r
);

  logic [bf5_pkg::CSUM_W-1:0] sums_r [WINDOW];
  logic [TOT_W-1:0]           total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        sums_r[k] <= '0;
      end
    end else if (ctl.valid) begin
      // A new frame drops the older columns before the shift.
      for (int k = 0; k < WINDOW - 1; k++) begin
        sums_r[k] <= ctl.clear ? '0 : sums_r[k+1];
      end
      sums_r[WINDOW-1] <= col_sum;
    end
  end

  always_comb begin
    total_nxt = '0;
    for (int k = 0; k < WINDOW; k++) begin
      total_nxt = total_nxt + TOT_W'(sums_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

endmodule

`default_nettype wire

@@ sv/bf5_out_fifo.sv @@
`default_nettype none

// Small result queue in front of the output channel.
module bf5_out_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire bf5_pkg::bf5_result_t            push_data,
  input  wire logic                            pop,
  output bf5_pkg::bf5_result_t                 head,
  output logic                                 not_empty,
  output logic [bf5_pkg::OUT_CNT_W-1:0]        count
);

  bf5_pkg::bf5_result_t                 mem_r [bf5_pkg::OUT_DEPTH];
  logic [bf5_pkg::OUT_PTR_W-1:0]        wr_ptr_r;
  logic [bf5_pkg::OUT_PTR_W-1:0]        rd_ptr_r;
  logic [bf5_pkg::OUT_CNT_W-1:0]        count_r;
  logic [bf5_pkg::OUT_CNT_W-1:0]        count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

`default_nettype wire

@@ sv/box_filter_5x5.sv @@
// Streaming box (mean) filter over a WINDOW x WINDOW neighborhood of 8-bit
// pixels. Pixels arrive on in_pix in raster order, one per beat, from a frame
// that has already been padded with zero rows and columns; frame_start marks
// the first pixel of a frame. Once the window is full, each pixel beat yields
// one beat on out_res with floor(window sum / WINDOW^2) and the padded-frame
// coordinates of the window center. Other beats give no result.
// cfg_we/cfg_wdata write the padded frame width, clamped to WINDOW..MAX_WIDTH;
// write it only while the block is idle. Reset sets the width to 640 and
// clears the counters and column sums. The line stores are not cleared, so
// every frame must begin with frame_start.
// Throughput is one pixel per cycle while in_pix.ready is high, limited by the
// single read and write port of each line store in the cell chain. A result
// passes the pipeline registers and the output queue before it is valid on out_res.
// When the receiver stalls, results collect in an eight-entry queue and in_pix.ready
// drops as soon as the queue plus the beats still in the pipeline could fill it.
`default_nettype none

module box_filter_5x5 #(
  parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW    = bf5_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bf5_pix_if.sink                           in_pix,
  bf5_res_if.source                         out_res,
  input  wire logic                         cfg_we,
  input  wire logic [bf5_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW     = (bf5_pkg::CFG_W > CW + 1) ? bf5_pkg::CFG_W : CW + 1;
  localparam int NCELL  = WINDOW - 1;
  localparam int HALF   = WINDOW / 2;
  localparam int AREA   = WINDOW * WINDOW;
  localparam int TOT_W  = $clog2(AREA * bf5_pkg::PIX_MAX + 1);
  // Reciprocal of the window area, exact for every possible total.
  localparam int SHIFT  = TOT_W + $clog2(AREA);
  localparam int RECIP  = ((1 << SHIFT) + AREA - 1) / AREA;
  localparam int RCP_W  = SHIFT + 1;
  localparam int PROD_W = TOT_W + RCP_W;
  localparam int OCC_W  = bf5_pkg::OUT_CNT_W + 1;
  localparam int EFFW_RST_I = (bf5_pkg::FW_RESET < WINDOW) ? WINDOW :
                              (bf5_pkg::FW_RESET > MAX_WIDTH) ? MAX_WIDTH :
                              bf5_pkg::FW_RESET;

  localparam logic [EW-1:0]               WIN_E    = EW'(WINDOW);
  localparam logic [EW-1:0]               MAXW_E   = EW'(MAX_WIDTH);
  localparam logic [EW-1:0]               HALF_E   = EW'(HALF);
  localparam logic [EW-1:0]               EFFW_RST = EW'(EFFW_RST_I);
  localparam logic [bf5_pkg::COORD_W-1:0] HALF_C   = bf5_pkg::COORD_W'(HALF);
  localparam logic [bf5_pkg::COORD_W-1:0] EDGE_C   = bf5_pkg::COORD_W'(WINDOW - 1);
  localparam logic [CW-1:0]               EDGE_A   = CW'(WINDOW - 1);
  localparam logic [PROD_W-1:0]           RECIP_P  = PROD_W'(RECIP);
  localparam logic [OCC_W-1:0]            DEPTH_O  = OCC_W'(bf5_pkg::OUT_DEPTH);

  // Frame width register, stored already clamped.
  logic [EW-1:0] effw_r;
  logic [EW-1:0] effw_nxt;
  logic [EW-1:0] cfg_ext;

  always_comb begin
    cfg_ext = EW'(cfg_wdata);
    if (cfg_ext < WIN_E) begin
      effw_nxt = WIN_E;
    end else if (cfg_ext > MAXW_E) begin
      effw_nxt = MAXW_E;
    end else begin
      effw_nxt = cfg_ext;
    end
  end

  // Position counters. A frame start forces the beat to the top-left corner;
  // a column left past the end by a narrower width restarts the row.
  logic                          accept;
  logic [CW-1:0]                 col_r;
  logic [bf5_pkg::COORD_W-1:0]   row_r;
  logic [CW-1:0]                 col_base;
  logic [CW-1:0]                 cur_col;
  logic [bf5_pkg::COORD_W-1:0]   cur_row;
  logic [EW-1:0]                 col_inc;
  logic                          row_wrap;
  logic [CW-1:0]                 col_nxt;
  logic [bf5_pkg::COORD_W-1:0]   row_nxt;

  assign accept = in_pix.valid && in_pix.ready;

  always_comb begin
    col_base = in_pix.frame_start ? '0 : col_r;
    cur_row  = in_pix.frame_start ? '0 : row_r;
    cur_col  = (EW'(col_base) >= effw_r) ? '0 : col_base;
    col_inc  = EW'(cur_col) + EW'(1);
    row_wrap = (col_inc >= effw_r);
    col_nxt  = row_wrap ? '0 : col_inc[CW-1:0];
    row_nxt  = (row_wrap && (cur_row != bf5_pkg::ROW_MAX)) ? cur_row + 1'b1 : cur_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      effw_r <= EFFW_RST;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cfg_we) begin
        effw_r <= effw_nxt;
      end
    end
  end

  // Stage 1: line store data for the accepted beat is on the cell taps.
  logic                          s1_v_r;
  logic                          s1_fs_r;
  logic [bf5_pkg::PIX_W-1:0]     s1_pix_r;
  logic [CW-1:0]                 s1_col_r;
  logic [bf5_pkg::COORD_W-1:0]   s1_row_r;

  // Stage 2: column sums updated. Stage 3: window total registered.
  logic                          s2_v_r;
  logic                          s2_emit_r;
  logic [bf5_pkg::COORD_W-1:0]   s2_crow_r;
  logic [bf5_pkg::COORD_W-1:0]   s2_ccol_r;
  logic                          s3_v_r;
  logic                          s3_emit_r;
  logic [bf5_pkg::COORD_W-1:0]   s3_crow_r;
  logic [bf5_pkg::COORD_W-1:0]   s3_ccol_r;

  logic                          s1_emit;
  logic [bf5_pkg::COORD_W-1:0]   s1_crow;
  logic [EW-1:0]                 s1_ccol_e;

  assign s1_emit   = (s1_row_r >= EDGE_C) && (s1_col_r >= EDGE_A);
  assign s1_crow   = s1_row_r - HALF_C;
  assign s1_ccol_e = EW'(s1_col_r) - HALF_E;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_fs_r   <= in_pix.frame_start;
    s1_pix_r  <= in_pix.pixel;
    s1_col_r  <= cur_col;
    s1_row_r  <= cur_row;
    s2_emit_r <= s1_emit;
    s2_crow_r <= s1_crow;
    s2_ccol_r <= s1_ccol_e[bf5_pkg::COORD_W-1:0];
    s3_emit_r <= s2_emit_r;
    s3_crow_r <= s2_crow_r;
    s3_ccol_r <= s2_ccol_r;
  end

  // Chain of line store cells. Every cell reads at the new column in the
  // accept cycle and writes the sample from the cell above in the cycle after,
  // so the rows shift down by one at that column while the sum builds up.
  bf5_pkg::bf5_mem_ctl_t          mem_ctl;
  logic [bf5_pkg::PIX_W-1:0]      wd [NCELL];
  logic [bf5_pkg::CSUM_W-1:0]     ps [NCELL+1];

  assign mem_ctl.rd_en = accept;
  assign mem_ctl.wr_en = s1_v_r;
  assign wd[0]         = s1_pix_r;
  assign ps[0]         = bf5_pkg::CSUM_W'(s1_pix_r);

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k < NCELL - 1) begin : g_mid
      bf5_line_cell #(
        .DEPTH (MAX_WIDTH)
      ) u_cell (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (cur_col),
        .wr_addr (s1_col_r),
        .wr_data (wd[k]),
        .sum_in  (ps[k]),
        .sum_out (ps[k+1]),
        .tap_out (wd[k+1])
      );
    end else begin : g_last
      // The oldest row's tap is not passed on; its sample falls off the bottom.
      bf5_line_cell #(
        .DEPTH (MAX_WIDTH)
      ) u_cell (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (cur_col),
        .wr_addr (s1_col_r),
        .wr_data (wd[k]),
        .sum_in  (ps[k]),
        .sum_out (ps[k+1]),
        .tap_out ()
      );
    end
  end

  // Horizontal sum over the last WINDOW columns.
  bf5_pkg::bf5_col_ctl_t col_ctl;
  logic [TOT_W-1:0]      total;

  assign col_ctl.valid = s1_v_r;
  assign col_ctl.clear = s1_fs_r;

  bf5_window_sum #(
    .WINDOW (WINDOW)
  ) u_window_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (col_ctl),
    .col_sum (ps[NCELL]),
    .total_r (total)
  );

  // Division by the window area as a multiply by its scaled reciprocal.
  logic [PROD_W-1:0]     prod;
  bf5_pkg::bf5_result_t  res;

  assign prod           = PROD_W'(total) * RECIP_P;
  assign res.mean_value = prod[SHIFT +: bf5_pkg::PIX_W];
  assign res.center_row = s3_crow_r;
  assign res.center_col = s3_ccol_r;

  // Output queue. Beats in flight hold a place, so a push never overflows.
  bf5_pkg::bf5_result_t            head;
  logic                            q_not_empty;
  logic [bf5_pkg::OUT_CNT_W-1:0]   q_count;
  logic [OCC_W-1:0]                occ;

  bf5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r && s3_emit_r),
    .push_data (res),
    .pop       (out_res.valid && out_res.ready),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign occ = OCC_W'(q_count) + OCC_W'(s1_v_r) + OCC_W'(s2_v_r) + OCC_W'(s3_v_r);
  assign in_pix.ready = (occ < DEPTH_O);

  assign out_res.valid      = q_not_empty;
  assign out_res.mean_value = head.mean_value;
  assign out_res.center_row = head.center_row;
  assign out_res.center_col = head.center_col;

endmodule

`default_nettype wire
